### rtl/core/art_pkg.sv
// Package for the address region table: sizing constants, operation,
// status and window-register index codes, and the sequencer state type. No dependencies.
package art_pkg;

  localparam int unsigned MaxRegionsDef = 16;
  localparam int unsigned PageBitsDef   = 12;
  localparam int unsigned AddrW         = 32;
  localparam int unsigned EndW          = 33;

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_CHECK  = 2'd1,
    FUNC_MAP    = 2'd2,
    FUNC_UNMAP  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    CFG_LOWEST  = 1'b0,
    CFG_HIGHEST = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_SHIFT,
    S_INSERT,
    S_DONE
  } state_t;

endpackage

### rtl/core/address_region_table_top.sv
// Address region table top level: sorted region memory with a read,
// evaluate and write-back sequencer. Depends on art_pkg.
//
// Lookup, check and unmap read and evaluate the regions in order until the
// result is known (one read and one evaluation per region scanned). A map
// that inserts then shifts the later entries up and writes the new region.
// Only one item is in flight: no new input is taken until the result has
// been transferred.
// Reset: synchronous active-low rst_n clears the sequencer, the region count and
// the output valid, and sets the window registers to their defaults; region memory is not cleared.
module address_region_table_top #(
  parameter int unsigned MAX_REGIONS = art_pkg::MaxRegionsDef,
  parameter int unsigned PAGE_BITS   = art_pkg::PageBitsDef
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [art_pkg::EndW-1:0] cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_func,
  input  logic [art_pkg::AddrW-1:0] in_address,
  input  logic [art_pkg::AddrW-1:0] in_length,
  input  logic                    in_write_check,
  input  logic                    in_fixed_placement,
  input  logic                    in_grant_write,
  input  logic [art_pkg::AddrW-1:0] in_file_offset,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_status,
  output logic [art_pkg::AddrW-1:0] out_result_address,
  output logic [art_pkg::AddrW-1:0] out_found_start,
  output logic [art_pkg::EndW-1:0] out_found_end,
  output logic                    out_found_writable
);
  import art_pkg::*;

  localparam int unsigned IdxW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CntW = $clog2(MAX_REGIONS + 1);
  localparam int unsigned WideW = 34;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_REGIONS);
  localparam logic [WideW-1:0] PageMask = WideW'((34'd1 << PAGE_BITS) - 34'd1);
  localparam logic [WideW-1:0] TopSpace = 34'h1_0000_0000;
  localparam int unsigned EntW = AddrW + EndW + 1;

  // Region memory: each entry packs begin, limit and write permission.
  logic [EntW-1:0] mem [MAX_REGIONS];
  logic [EntW-1:0] rd_data_r;
  logic [IdxW-1:0] rd_addr;
  logic            mem_we;
  logic [IdxW-1:0] wr_addr;
  logic [EntW-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Window registers.
  logic [AddrW-1:0] lowest_r;
  logic [EndW-1:0]  highest_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lowest_r  <= AddrW'(4096);
      highest_r <= EndW'(34'h0_8000_0000);
    end else if (cfg_we) begin
      if (cfg_index == CFG_LOWEST) begin
        lowest_r <= cfg_wdata[AddrW-1:0];
      end else begin
        highest_r <= cfg_wdata;
      end
    end
  end

  // Sequencer registers.
  state_t           state_r, state_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic [CntW-1:0]  i_r, i_nxt;       // read index
  logic [CntW-1:0]  w_r, w_nxt;       // unmap write index
  logic [1:0]       func_r;
  logic             wr_chk_r, fixed_r, grant_r;
  logic [WideW-1:0] start_r, start_nxt;
  logic [WideW-1:0] end_r, end_nxt;
  logic [WideW-1:0] len_r;
  logic             pos_found_r, pos_found_nxt;
  logic [CntW-1:0]  pos_r, pos_nxt;
  logic             fail_r, fail_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [AddrW-1:0] fs_r, fs_nxt;
  logic [EndW-1:0]  fe_r, fe_nxt;
  logic             fw_r, fw_nxt;
  logic [AddrW-1:0] ra_r, ra_nxt;
  logic             ov_r, ov_nxt;

  // Input decode, done at acceptance.
  logic [WideW-1:0] in_page_start, in_len, in_unmap_end, in_map_len, hi_clip;
  logic             in_fo_bad;
  assign in_page_start = {2'b0, in_address} & ~PageMask;
  assign in_len        = {2'b0, in_length};
  assign in_unmap_end  = ({2'b0, in_address} + in_len + PageMask) & ~PageMask;
  assign in_map_len    = in_len + ({2'b0, in_file_offset} & PageMask);
  assign in_fo_bad     = (({2'b0, in_file_offset} ^ {2'b0, in_address}) & PageMask) != '0;
  assign hi_clip       = ({1'b0, highest_r} > TopSpace) ? TopSpace : {1'b0, highest_r};

  // Current entry fields.
  logic [WideW-1:0] eb, ee;
  logic             ew;
  assign eb = {2'b0, rd_data_r[EntW-1 -: AddrW]};
  assign ee = {1'b0, rd_data_r[EndW:1]};
  assign ew = rd_data_r[0];

  logic fire_in;
  assign in_ready = (state_r == S_IDLE) && !ov_r;
  assign fire_in  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    w_r <= w_nxt;
    start_r <= start_nxt;
    end_r <= end_nxt;
    pos_found_r <= pos_found_nxt;
    pos_r <= pos_nxt;
    fail_r <= fail_nxt;
    status_r <= status_nxt;
    fs_r <= fs_nxt;
    fe_r <= fe_nxt;
    fw_r <= fw_nxt;
    ra_r <= ra_nxt;
    if (fire_in) begin
      func_r   <= in_func;
      wr_chk_r <= in_write_check;
      fixed_r  <= in_fixed_placement;
      grant_r  <= in_grant_write;
      len_r    <= in_map_len;
    end
  end

  // Next state and memory control.
  logic [WideW-1:0] nb, ne, ns;
  logic             keep;
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    i_nxt = i_r;
    w_nxt = w_r;
    start_nxt = start_r;
    end_nxt = end_r;
    pos_found_nxt = pos_found_r;
    pos_nxt = pos_r;
    fail_nxt = fail_r;
    status_nxt = status_r;
    fs_nxt = fs_r;
    fe_nxt = fe_r;
    fw_nxt = fw_r;
    ra_nxt = ra_r;
    ov_nxt = ov_r;
    mem_we = 1'b0;
    wr_addr = w_r[IdxW-1:0];
    wr_data = rd_data_r;
    rd_addr = i_r[IdxW-1:0];
    nb = eb;
    ne = ee;
    ns = start_r;
    keep = 1'b1;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (fire_in) begin
          i_nxt = '0;
          w_nxt = '0;
          pos_found_nxt = 1'b0;
          pos_nxt = count_r;
          fail_nxt = 1'b0;
          status_nxt = ST_REFUSED;
          fs_nxt = '0;
          fe_nxt = '0;
          fw_nxt = 1'b0;
          ra_nxt = '0;
          state_nxt = S_READ;
          unique case (func_t'(in_func))
            FUNC_LOOKUP: begin
              start_nxt = {2'b0, in_address};
            end
            FUNC_CHECK: begin
              start_nxt = {2'b0, in_address};
              end_nxt = {2'b0, in_address} + in_len;
              if (in_length == '0 || ({2'b0, in_address} + in_len) > TopSpace) begin
                state_nxt = S_DONE;
              end
            end
            FUNC_MAP: begin
              if (in_fo_bad) begin
                state_nxt = S_DONE;
              end else if (in_fixed_placement) begin
                start_nxt = in_page_start;
                end_nxt = in_page_start + in_map_len;
                if (in_page_start < {2'b0, lowest_r}
                    || hi_clip < in_page_start + in_map_len
                    || in_page_start + in_map_len <= in_page_start) begin
                  state_nxt = S_DONE;
                end
              end else begin
                ns = (in_page_start < {2'b0, lowest_r}) ? {2'b0, lowest_r} : in_page_start;
                start_nxt = ns;
                end_nxt = ns + in_map_len;
              end
            end
            default: begin
              start_nxt = in_page_start;
              end_nxt = in_unmap_end;
              status_nxt = ST_OK;
              if (in_unmap_end <= in_page_start) begin
                state_nxt = S_DONE;
              end
            end
          endcase
        end
      end
      S_READ: begin
        // Address i_r is presented; data lands in rd_data_r next cycle.
        if (i_r >= count_r) begin
          state_nxt = S_DONE;
          if (func_t'(func_r) == FUNC_UNMAP) begin
            count_nxt = w_r;
          end else if (func_t'(func_r) == FUNC_MAP) begin
            if (!fixed_r && (hi_clip < end_r || end_r <= start_r)) begin
              status_nxt = ST_REFUSED;
            end else if (count_r >= MaxCnt) begin
              status_nxt = ST_FULL;
            end else begin
              status_nxt = ST_OK;
              ra_nxt = start_r[AddrW-1:0];
              // Shift entries from the top down to the insert position.
              i_nxt = count_r;
              state_nxt = S_SHIFT;
            end
          end
        end else begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_READ;
        i_nxt = i_r + 1'b1;
        unique case (func_t'(func_r))
          FUNC_LOOKUP: begin
            if (ee > start_r) begin
              if (eb <= start_r) begin
                status_nxt = ST_OK;
                fs_nxt = eb[AddrW-1:0];
                fe_nxt = ee[EndW-1:0];
                fw_nxt = ew;
              end
              state_nxt = S_DONE;
            end
          end
          FUNC_CHECK: begin
            if (start_r < eb) begin
              state_nxt = S_DONE;
            end else if (start_r < ee) begin
              if (wr_chk_r && !ew) begin
                state_nxt = S_DONE;
              end else if (ee < end_r) begin
                start_nxt = ee;
              end else begin
                status_nxt = ST_OK;
                state_nxt = S_DONE;
              end
            end
          end
          FUNC_MAP: begin
            if (end_r <= eb) begin
              pos_nxt = i_r;
              i_nxt = count_r;
            end else if (start_r < ee) begin
              if (fixed_r) begin
                state_nxt = S_DONE;
              end else begin
                start_nxt = ee;
                end_nxt = ee + len_r;
              end
            end
          end
          default: begin
            if (end_r > eb && ee > start_r) begin
              if (start_r <= eb && ee <= end_r) begin
                keep = 1'b0;
              end else if (eb < start_r) begin
                ne = start_r;
              end else if (end_r < ee) begin
                nb = end_r;
              end
            end
            if (keep) begin
              mem_we = 1'b1;
              wr_addr = w_r[IdxW-1:0];
              wr_data = {nb[AddrW-1:0], ne[EndW-1:0], ew};
              w_nxt = w_r + 1'b1;
            end
          end
        endcase
      end
      S_SHIFT: begin
        // i_r is the slot being filled; read the entry below it.
        if (i_r == pos_r) begin
          state_nxt = S_INSERT;
        end else begin
          rd_addr = IdxW'(i_r - 1'b1);
          state_nxt = S_INSERT;
          pos_found_nxt = 1'b1;
        end
      end
      S_INSERT: begin
        mem_we = 1'b1;
        wr_addr = i_r[IdxW-1:0];
        if (pos_found_r) begin
          wr_data = rd_data_r;
          pos_found_nxt = 1'b0;
          i_nxt = i_r - 1'b1;
          state_nxt = S_SHIFT;
        end else begin
          wr_data = {start_r[AddrW-1:0], end_r[EndW-1:0], grant_r};
          count_nxt = count_r + 1'b1;
          state_nxt = S_DONE;
        end
      end
      default: begin
        // Result register: present one transfer.
        if (fixed_r && func_t'(func_r) == FUNC_MAP && status_r == ST_REFUSED
            && fail_r) begin
          status_nxt = ST_REFUSED;
        end
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid          = ov_r;
  assign out_status         = status_r;
  assign out_result_address = ra_r;
  assign out_found_start    = fs_r;
  assign out_found_end      = fe_r;
  assign out_found_writable = fw_r;

endmodule

### rtl/core/art_checker.sv
// Port-level checker for the address region table, bound to the top level.
// Depends on art_pkg for status codes.
module art_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status
);
  import art_pkg::*;

  // Only one item is in flight: no input while a result waits.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  // Status is never an unused code.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_REFUSED
                   || out_status == ST_FULL)) else $error("bad status");

  // A pending result holds until transferred.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped");

  // An accepted item blocks further input on the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("accepted twice");

endmodule

bind address_region_table_top art_checker u_art_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status)
);

### verif/tb_address_region_table_top.sv
// Self-checking testbench for address_region_table_top: a local table predictor
// computes each expected result, which is compared with the block's output.
// Depends on art_pkg and the address_region_table_top RTL.
module tb_address_region_table_top;
  timeunit 1ns;
  timeprecision 1ps;
  import art_pkg::*;

  localparam int unsigned NREG = 16;
  localparam int unsigned PB = 12;
  localparam logic [63:0] PMASK = (64'd1 << PB) - 64'd1;
  localparam logic [63:0] SPACE_TOP = 64'd1 << 32;

  typedef struct packed {
    func_t       func;
    logic [31:0] address;
    logic [31:0] length;
    logic        write_check;
    logic        fixed_placement;
    logic        grant_write;
    logic [31:0] file_offset;
  } op_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] result_address;
    logic [31:0] found_start;
    logic [32:0] found_end;
    logic        found_writable;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [32:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func = '0;
  logic [31:0] in_address = '0;
  logic [31:0] in_length = '0;
  logic        in_write_check = 1'b0;
  logic        in_fixed_placement = 1'b0;
  logic        in_grant_write = 1'b0;
  logic [31:0] in_file_offset = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_result_address;
  logic [31:0] out_found_start;
  logic [32:0] out_found_end;
  logic        out_found_writable;

  address_region_table_top uut (.*);

  initial forever #5 clk = ~clk;

  // Predictor state: a sorted copy of the region table and the user window.
  logic [63:0] win_low, win_high;
  logic [63:0] tbl_begin [NREG];
  logic [63:0] tbl_end [NREG];
  logic        tbl_wr [NREG];
  int unsigned tbl_count;

  op_t     pending_ops[$];
  answer_t expected_answers[$];
  int      fail_count = 0;
  bit      stimulus_done = 1'b0;
  bit      hold_sender = 1'b0;
  bit      long_stall = 1'b0;

  function automatic status_t predict_check(logic [63:0] s, logic [63:0] len, bit wr);
    logic [63:0] e;
    e = s + len;
    if (len == 0 || e > SPACE_TOP) return ST_REFUSED;
    for (int i = 0; i < tbl_count; i++) begin
      if (s < tbl_begin[i]) return ST_REFUSED;
      if (s < tbl_end[i]) begin
        if (wr && !tbl_wr[i]) return ST_REFUSED;
        if (tbl_end[i] < e) begin
          s = tbl_end[i];
          continue;
        end
        return ST_OK;
      end
    end
    return ST_REFUSED;
  endfunction

  function automatic status_t predict_map(op_t op, output logic [31:0] chosen);
    logic [63:0] s, len, e, hi;
    int unsigned pos;
    chosen = '0;
    hi = (win_high > SPACE_TOP) ? SPACE_TOP : win_high;
    if ((op.file_offset & PMASK) != (op.address & PMASK)) return ST_REFUSED;
    s = {32'd0, op.address} & ~PMASK;
    len = {32'd0, op.length} + ({32'd0, op.file_offset} & PMASK);
    pos = tbl_count;
    if (op.fixed_placement) begin
      if (s < win_low) return ST_REFUSED;
      e = s + len;
      if (hi < e || e <= s) return ST_REFUSED;
      for (int i = 0; i < tbl_count; i++) begin
        if (e <= tbl_begin[i]) begin
          pos = i;
          break;
        end
        if (s < tbl_end[i]) return ST_REFUSED;
      end
    end else begin
      if (s < win_low) s = win_low;
      e = s + len;
      for (int i = 0; i < tbl_count; i++) begin
        if (e <= tbl_begin[i]) begin
          pos = i;
          break;
        end
        if (s < tbl_end[i]) begin
          s = tbl_end[i];
          e = s + len;
        end
      end
      if (hi < e || e <= s) return ST_REFUSED;
    end
    if (tbl_count >= NREG) return ST_FULL;
    for (int k = tbl_count; k > pos; k--) begin
      tbl_begin[k] = tbl_begin[k-1];
      tbl_end[k] = tbl_end[k-1];
      tbl_wr[k] = tbl_wr[k-1];
    end
    tbl_begin[pos] = s;
    tbl_end[pos] = e;
    tbl_wr[pos] = op.grant_write;
    tbl_count++;
    chosen = s[31:0];
    return ST_OK;
  endfunction

  function automatic void predict_unmap(logic [63:0] a, logic [63:0] len);
    logic [63:0] s, e, b, t;
    int unsigned w;
    bit keep;
    s = a & ~PMASK;
    e = (a + len + PMASK) & ~PMASK;
    w = 0;
    if (e <= s) return;
    for (int i = 0; i < tbl_count; i++) begin
      b = tbl_begin[i];
      t = tbl_end[i];
      keep = 1'b1;
      if (e > b && t > s) begin
        if (s <= b && t <= e) keep = 1'b0;
        else if (b < s) t = s;
        else if (e < t) b = e;
      end
      if (keep) begin
        tbl_begin[w] = b;
        tbl_end[w] = t;
        tbl_wr[w] = tbl_wr[i];
        w++;
      end
    end
    tbl_count = w;
  endfunction

  function automatic answer_t predict_answer(op_t op);
    answer_t r;
    r = '0;
    r.status = ST_REFUSED;
    case (op.func)
      FUNC_LOOKUP: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_end[i] <= op.address) continue;
          if (tbl_begin[i] <= op.address) begin
            r.status = ST_OK;
            r.found_start = tbl_begin[i][31:0];
            r.found_end = tbl_end[i][32:0];
            r.found_writable = tbl_wr[i];
          end
          break;
        end
      end
      FUNC_CHECK: r.status = predict_check(op.address, op.length, op.write_check);
      FUNC_MAP: r.status = predict_map(op, r.result_address);
      default: begin
        predict_unmap(op.address, op.length);
        r.status = ST_OK;
      end
    endcase
    return r;
  endfunction

  // Driver: offers items from the pending queue in bursts separated by gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_answers.push_back(predict_answer(pending_ops.pop_front()));
      end
      if (in_valid && !in_ready) begin
        // Hold the current item until the block accepts it.
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_ops.size() > 0 && !hold_sender
                   && !(in_valid && in_ready && pending_ops.size() == 0)) begin
        in_valid <= 1'b1;
        in_func <= pending_ops[0].func;
        in_address <= pending_ops[0].address;
        in_length <= pending_ops[0].length;
        in_write_check <= pending_ops[0].write_check;
        in_fixed_placement <= pending_ops[0].fixed_placement;
        in_grant_write <= pending_ops[0].grant_write;
        in_file_offset <= pending_ops[0].file_offset;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each transfer on the result channel with the oldest
  // expectation. The receiver stalls on a slowly varying duty pattern.
  int stall_phase = 0;
  int stall_mode = 0;
  answer_t want;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          $error("result transfer with no expectation pending");
          fail_count++;
        end else begin
          want = expected_answers.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, out_status);
            fail_count++;
          end
          if (out_result_address !== want.result_address) begin
            $error("result_address: expected %h actual %h", want.result_address,
                   out_result_address);
            fail_count++;
          end
          if (out_found_start !== want.found_start) begin
            $error("found_start: expected %h actual %h", want.found_start, out_found_start);
            fail_count++;
          end
          if (out_found_end !== want.found_end) begin
            $error("found_end: expected %h actual %h", want.found_end, out_found_end);
            fail_count++;
          end
          if (out_found_writable !== want.found_writable) begin
            $error("found_writable: expected %b actual %b", want.found_writable,
                   out_found_writable);
            fail_count++;
          end
        end
      end
      stall_phase <= stall_phase + 1;
      if (stall_phase % 200 == 0) stall_mode <= $urandom_range(0, 3);
      if (long_stall) out_ready <= 1'b0;
      else case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= (stall_phase % 7 < 3);
        default: out_ready <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  task automatic write_window(cfg_idx_t idx, logic [32:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LOWEST) win_low = {32'd0, value[31:0]};
    else win_high = {31'd0, value};
  endtask

  // Waits until every queued item has been accepted and answered, then lets
  // the block settle before anything else happens.
  task automatic drain_all();
    while (pending_ops.size() > 0 || in_valid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic op_t make_op(func_t f, logic [31:0] a, logic [31:0] l,
                                  bit wc, bit fx, bit gw, logic [31:0] fo);
    op_t o;
    o.func = f;
    o.address = a;
    o.length = l;
    o.write_check = wc;
    o.fixed_placement = fx;
    o.grant_write = gw;
    o.file_offset = fo;
    return o;
  endfunction

  // Random item, mostly page-scale operations near the window so that maps
  // collide, lookups hit and unmaps trim; a share of raw 32-bit noise.
  function automatic op_t random_op();
    op_t o;
    logic [31:0] base;
    base = win_low[31:0] + ($urandom_range(0, 40) << PB);
    o.func = func_t'($urandom_range(0, 3));
    o.address = base + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : 0);
    o.length = $urandom_range(0, 6) << PB;
    if ($urandom_range(0, 3) == 0) o.length += $urandom_range(0, 4095);
    o.write_check = $urandom_range(0, 1);
    o.fixed_placement = $urandom_range(0, 1);
    o.grant_write = $urandom_range(0, 1);
    o.file_offset = ($urandom() & ~32'hFFF) | (o.address & 32'hFFF);
    if ($urandom_range(0, 15) == 0) o.file_offset = $urandom();
    if ($urandom_range(0, 19) == 0) begin
      o.address = $urandom();
      o.length = $urandom();
    end
    return o;
  endfunction

  initial begin
    win_low = 64'd4096;
    win_high = 64'd1 << 31;
    tbl_count = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items: field extremes, each operation, offset mismatch,
    // table full, empty ranges and an unaligned zero-length unmap.
    pending_ops.push_back(make_op(FUNC_LOOKUP, 32'hFFFFFFFF, 0, 0, 0, 0, 0));
    pending_ops.push_back(make_op(FUNC_MAP, 32'h0000_2000, 32'h1000, 0, 1, 1, 0));
    pending_ops.push_back(make_op(FUNC_MAP, 32'h0000_2123, 32'h10, 0, 1, 0, 32'h5123));
    pending_ops.push_back(make_op(FUNC_MAP, 32'h0000_2123, 32'h10, 0, 0, 0, 32'h5124));
    pending_ops.push_back(make_op(FUNC_MAP, 32'h0, 32'h3000, 0, 0, 0, 32'hFFFFF000));
    pending_ops.push_back(make_op(FUNC_MAP, 32'h0, 32'h0, 0, 0, 1, 0));
    pending_ops.push_back(make_op(FUNC_MAP, 32'hFFFFF000, 32'hFFFFFFFF, 0, 1, 1, 0));
    pending_ops.push_back(make_op(FUNC_LOOKUP, 32'h2000, 0, 0, 0, 0, 0));
    pending_ops.push_back(make_op(FUNC_CHECK, 32'h1000, 32'h3000, 1, 0, 0, 0));
    pending_ops.push_back(make_op(FUNC_CHECK, 32'h1000, 32'h2000, 0, 0, 0, 0));
    pending_ops.push_back(make_op(FUNC_CHECK, 32'h1000, 0, 0, 0, 0, 0));
    pending_ops.push_back(make_op(FUNC_CHECK, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 0, 0, 0));
    for (int i = 0; i < 17; i++)
      pending_ops.push_back(make_op(FUNC_MAP, 0, 32'h1000, 0, 0, i % 2, 0));
    pending_ops.push_back(make_op(FUNC_UNMAP, 32'h2800, 0, 0, 0, 0, 0));
    pending_ops.push_back(make_op(FUNC_UNMAP, 32'h5000, 32'h2800, 0, 0, 0, 0));
    pending_ops.push_back(make_op(FUNC_UNMAP, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 1, 1, 0));
    pending_ops.push_back(make_op(FUNC_UNMAP, 32'h0, 32'hFFFFFFFF, 0, 0, 0, 0));
    drain_all();

    // Random phases across window settings, including both extremes.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_window(CFG_LOWEST, 33'd0);
          write_window(CFG_HIGHEST, 33'h1_FFFF_FFFF);
        end
        1: begin
          write_window(CFG_LOWEST, 33'h0_FFFF_FFFF);
          write_window(CFG_HIGHEST, 33'h1_0000_0000);
        end
        2: begin
          write_window(CFG_LOWEST, 33'h0_0001_0000);
          write_window(CFG_HIGHEST, 33'h0_0003_0000);
        end
        3: begin
          write_window(CFG_LOWEST, 33'h0_FFFE_0000);
          write_window(CFG_HIGHEST, 33'h1_0000_0000);
        end
        4: begin
          write_window(CFG_LOWEST, {1'b0, $urandom()} & 33'h0_7FFF_F000);
          write_window(CFG_HIGHEST, 33'h0);
        end
        default: begin
          write_window(CFG_LOWEST, 33'h0_0000_1000);
          write_window(CFG_HIGHEST, 33'h0_8000_0000);
        end
      endcase
      for (int n = 0; n < 270; n++) begin
        pending_ops.push_back(random_op());
        if (n % 45 == 0) pending_ops.push_back(make_op(FUNC_UNMAP, 0, 32'hFFFFFFFF,
                                                        0, 0, 0, 0));
      end
      if (ph == 2) begin
        // Long receiver hold-off while the sender keeps offering items.
        long_stall = 1'b1;
        repeat (400) @(posedge clk);
        long_stall = 1'b0;
      end
      if (ph == 3) begin
        // Sender pauses mid-phase until every expected result has come.
        while (pending_ops.size() > 130) @(posedge clk);
        hold_sender = 1'b1;
        while (in_valid || expected_answers.size() > 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      drain_all();
    end
    stimulus_done = 1'b1;
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

### files.f
rtl/core/art_pkg.sv
rtl/core/address_region_table_top.sv
rtl/core/art_checker.sv
verif/tb_address_region_table_top.sv
